/* sv/lsbbp_pkg.sv */
`timescale 1ns / 1ps
// Package for the LSB-first bit packer and unpacker.
// Holds the command codes, the sequencer states and the fixed field constants.
// No dependencies.
package lsbbp_pkg;

    typedef enum logic [2:0] {
        OP_WR_UINT  = 3'd0,
        OP_RD_UINT  = 3'd1,
        OP_WR_SINT  = 3'd2,
        OP_RD_SINT  = 3'd3,
        OP_WR_FLOAT = 3'd4,
        OP_RD_FLOAT = 3'd5,
        OP_SKIP     = 3'd6,
        OP_CLEAR    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_WRITE  = 2'd1,
        ST_READ   = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // widest integer field, widest kept mantissa, sign plus exponent bits of a float
    localparam logic [7:0] FIELD_MAX   = 8'd32;
    localparam logic [4:0] MANT_MAX    = 5'd23;
    localparam logic [5:0] FLOAT_HEAD  = 6'd9;
    // staging register holds a sign bit plus a 32-bit magnitude
    localparam int         STAGE_W     = 33;

endpackage

/* sv/lsbbp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/lsb_first_bit_packer_unpacker.sv */
`timescale 1ns / 1ps
// Top level of the LSB-first bit packer and unpacker; uses lsbbp_pkg and lsbbp_ram.
// Skip, clear, rejected commands and reads at the fill point go from accept straight
// to the finish state; other writes and reads pass through the write or read state once
// per byte touched (1 to 5). One item at a time, and the finish state holds while m_ready
// is low; the byte-wide store port moves one byte-aligned digit of up to 8 bits per cycle.
// Reset (aresetn low, synchronous) zeroes both cursors and empties the result register;
// the store is not cleared and needs no clearing pass.
module lsb_first_bit_packer_unpacker #(
    parameter int CAPACITY_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [31:0] s_value,
    input  logic [7:0]  s_width,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_ok,
    output logic        m_hit_end,
    output logic [15:0] m_fill_bits,
    output logic [15:0] m_read_bits
);

    localparam int CAP_BITS = CAPACITY_BYTES * 8;
    localparam int CUR_W    = $clog2(CAP_BITS + 1);
    localparam int ADDR_W   = $clog2(CAPACITY_BYTES);
    localparam int SW       = lsbbp_pkg::STAGE_W;

    // sequencer and cursors
    lsbbp_pkg::state_t state_reg, state_next;
    lsbbp_pkg::op_t    op_reg, op_next;
    logic [CUR_W-1:0]  wc_reg, wc_next;
    logic [CUR_W-1:0]  rc_reg, rc_next;

    // digit-serial datapath: write staging shifts out, read accumulator fills up
    logic [SW-1:0]     sh_reg, sh_next;
    logic [SW-1:0]     acc_reg, acc_next;
    logic [5:0]        rem_reg, rem_next;
    logic [5:0]        got_reg, got_next;
    logic [4:0]        mb_reg, mb_next;
    logic              ok_reg, ok_next;
    logic              end_reg, end_next;
    logic [7:0]        partial_reg, partial_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_read_data_reg, m_read_data_next;
    logic              m_ok_reg, m_ok_next;
    logic              m_hit_end_reg, m_hit_end_next;
    logic [15:0]       m_fill_reg, m_fill_next;
    logic [15:0]       m_read_reg, m_read_next;

    // store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    lsbbp_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready     = (state_reg == lsbbp_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_ok        = m_ok_reg;
    assign m_hit_end   = m_hit_end_reg;
    assign m_fill_bits = m_fill_reg;
    assign m_read_bits = m_read_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsbbp_pkg::ST_IDLE;
            op_reg      <= lsbbp_pkg::OP_CLEAR;
            wc_reg      <= '0;
            rc_reg      <= '0;
            rem_reg     <= '0;
            got_reg     <= '0;
            ok_reg      <= 1'b0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            wc_reg      <= wc_next;
            rc_reg      <= rc_next;
            rem_reg     <= rem_next;
            got_reg     <= got_next;
            ok_reg      <= ok_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        sh_reg          <= sh_next;
        acc_reg         <= acc_next;
        mb_reg          <= mb_next;
        partial_reg     <= partial_next;
        m_read_data_reg <= m_read_data_next;
        m_ok_reg        <= m_ok_next;
        m_hit_end_reg   <= m_hit_end_next;
        m_fill_reg      <= m_fill_next;
        m_read_reg      <= m_read_next;
    end

    // Next state and datapath.
    always_comb begin
        lsbbp_pkg::op_t   op_in;
        logic             wbad;
        logic [4:0]       mb_in;
        logic             neg;
        logic [31:0]      mag;
        logic [22:0]      mant;
        logic [5:0]       n_wr;
        logic [5:0]       n_rd;
        logic [SW-1:0]    wr_pat;
        logic             fits;
        logic [CUR_W-1:0] avail;
        logic             rd_short;
        logic [5:0]       take;
        logic [2:0]       off;
        logic [3:0]       room;
        logic [3:0]       k;
        logic [7:0]       wbyte;
        logic [7:0]       rbits;
        logic [31:0]      fill_w;
        logic [31:0]      read_w;
        logic [31:0]      smag;
        logic [22:0]      rmant;

        state_next       = state_reg;
        op_next          = op_reg;
        wc_next          = wc_reg;
        rc_next          = rc_reg;
        sh_next          = sh_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        got_next         = got_reg;
        mb_next          = mb_reg;
        ok_next          = ok_reg;
        end_next         = end_reg;
        partial_next     = partial_reg;
        m_valid_next     = m_valid_reg;
        m_read_data_next = m_read_data_reg;
        m_ok_next        = m_ok_reg;
        m_hit_end_next   = m_hit_end_reg;
        m_fill_next      = m_fill_reg;
        m_read_next      = m_read_reg;

        ram_we    = 1'b0;
        ram_waddr = wc_reg[ADDR_W+2:3];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = rc_reg[ADDR_W+2:3];

        // decode of the offered item
        op_in    = lsbbp_pkg::op_t'(s_opcode);
        wbad     = (s_width == 8'd0) || (s_width > lsbbp_pkg::FIELD_MAX);
        mb_in    = (s_width > 8'(lsbbp_pkg::MANT_MAX)) ? lsbbp_pkg::MANT_MAX : s_width[4:0];
        neg      = s_value[31];
        mag      = neg ? (32'd0 - s_value) : s_value;
        mant     = s_value[22:0] >> (lsbbp_pkg::MANT_MAX - mb_in);
        avail    = wc_reg - rc_reg;

        // bit count and bit pattern per command, sign bit first
        case (op_in)
            lsbbp_pkg::OP_WR_SINT, lsbbp_pkg::OP_RD_SINT: begin
                n_wr   = s_width[5:0] + 6'd1;
                wr_pat = {mag, neg};
            end
            lsbbp_pkg::OP_WR_FLOAT, lsbbp_pkg::OP_RD_FLOAT: begin
                n_wr   = lsbbp_pkg::FLOAT_HEAD + 6'(mb_in);
                wr_pat = {1'b0, mant, s_value[30:23], s_value[31]};
            end
            default: begin
                n_wr   = s_width[5:0];
                wr_pat = {1'b0, s_value};
            end
        endcase
        n_rd     = n_wr;
        fits     = ({1'b0, wc_reg} + (CUR_W+1)'(n_wr)) <= (CUR_W+1)'(CAP_BITS);
        rd_short = CUR_W'(n_rd) > avail;
        take     = rd_short ? avail[5:0] : n_rd;

        // one byte-aligned digit at the cursor of the active direction
        off   = (state_reg == lsbbp_pkg::ST_READ) ? rc_reg[2:0] : wc_reg[2:0];
        room  = 4'd8 - {1'b0, off};
        k     = (rem_reg < 6'(room)) ? rem_reg[3:0] : room;
        wbyte = (partial_reg & ~(8'hFF << off)) | 8'(sh_reg[7:0] << off);
        rbits = (ram_rdata >> off) & ~(8'hFF << k);

        fill_w = 32'(wc_reg);
        read_w = 32'(rc_reg);
        smag   = acc_reg[32:1];
        rmant  = acc_reg[31:9] << (lsbbp_pkg::MANT_MAX - mb_reg);

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            lsbbp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next    = op_in;
                    mb_next    = mb_in;
                    ok_next    = 1'b1;
                    end_next   = 1'b0;
                    acc_next   = '0;
                    got_next   = '0;
                    rem_next   = '0;
                    state_next = lsbbp_pkg::ST_FINISH;
                    case (op_in)
                        lsbbp_pkg::OP_WR_UINT, lsbbp_pkg::OP_WR_SINT,
                        lsbbp_pkg::OP_WR_FLOAT: begin
                            // reject a bad integer width or an overflowing write whole
                            if ((wbad && op_in != lsbbp_pkg::OP_WR_FLOAT) || !fits) begin
                                ok_next = 1'b0;
                            end else begin
                                sh_next    = wr_pat;
                                rem_next   = n_wr;
                                state_next = lsbbp_pkg::ST_WRITE;
                            end
                        end
                        lsbbp_pkg::OP_RD_UINT, lsbbp_pkg::OP_RD_SINT,
                        lsbbp_pkg::OP_RD_FLOAT: begin
                            if (wbad && op_in != lsbbp_pkg::OP_RD_FLOAT) begin
                                ok_next = 1'b0;
                            end else begin
                                // stop at the fill point, unread bits stay zero
                                end_next = rd_short;
                                rem_next = take;
                                if (take != 6'd0) begin
                                    ram_re     = 1'b1;
                                    state_next = lsbbp_pkg::ST_READ;
                                end
                            end
                        end
                        lsbbp_pkg::OP_SKIP: begin
                            if (s_value > 32'(avail)) begin
                                end_next = 1'b1;
                                rc_next  = wc_reg;
                            end else begin
                                rc_next = rc_reg + CUR_W'(s_value);
                            end
                        end
                        lsbbp_pkg::OP_CLEAR: begin
                            wc_next = '0;
                            rc_next = '0;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            lsbbp_pkg::ST_WRITE: begin
                // merge the digit above the bits already held in the open byte
                ram_we       = 1'b1;
                ram_wdata    = wbyte;
                partial_next = wbyte;
                wc_next      = wc_reg + CUR_W'(k);
                sh_next      = sh_reg >> k;
                rem_next     = rem_reg - 6'(k);
                if (rem_reg == 6'(k)) begin
                    state_next = lsbbp_pkg::ST_FINISH;
                end
            end
            lsbbp_pkg::ST_READ: begin
                // byte at the read cursor is here; fetch the next one meanwhile
                ram_re    = 1'b1;
                ram_raddr = rc_reg[ADDR_W+2:3] + ADDR_W'(1);
                acc_next  = acc_reg | SW'({{(SW-8){1'b0}}, rbits} << got_reg);
                got_next  = got_reg + 6'(k);
                rc_next   = rc_reg + CUR_W'(k);
                rem_next  = rem_reg - 6'(k);
                if (rem_reg == 6'(k)) begin
                    state_next = lsbbp_pkg::ST_FINISH;
                end
            end
            lsbbp_pkg::ST_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_ok_next      = ok_reg;
                    m_hit_end_next = end_reg;
                    m_fill_next    = fill_w[15:0];
                    m_read_next    = read_w[15:0];
                    case (op_reg)
                        lsbbp_pkg::OP_RD_UINT:  m_read_data_next = acc_reg[31:0];
                        lsbbp_pkg::OP_RD_SINT:  m_read_data_next = acc_reg[0] ?
                                                    (32'd0 - smag) : smag;
                        lsbbp_pkg::OP_RD_FLOAT: m_read_data_next = {acc_reg[0],
                                                    acc_reg[8:1], rmant};
                        default:                m_read_data_next = '0;
                    endcase
                    state_next = lsbbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsbbp_pkg::ST_IDLE;
            end
        endcase
    end

    // The read cursor never passes the fill point.
    a_rc_le_wc: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_reg <= wc_reg)
        else $error("read cursor beyond fill point");

    // The fill point never passes the store capacity.
    a_wc_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        wc_reg <= CUR_W'(CAP_BITS))
        else $error("fill point beyond capacity");

    // A transfer state always has bits left to move.
    a_rem_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsbbp_pkg::ST_WRITE || state_reg == lsbbp_pkg::ST_READ)
        |-> (rem_reg != 6'd0))
        else $error("transfer state with nothing to move");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != lsbbp_pkg::ST_IDLE))
        else $error("item accepted without starting work");

endmodule
